// ===== rtl/core/hls_to_rgb_converter_defines.svh =====
// Assertion macros shared by the converter RTL.
`ifndef HLS_TO_RGB_CONVERTER_DEFINES_SVH
`define HLS_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hrc_pkg.sv =====
package hrc_pkg;

    localparam int FIELD_W   = 13;
    localparam int FRAC_BITS = 12;

    localparam logic [FIELD_W-1:0] ONE_Q  = FIELD_W'(1) << FRAC_BITS;
    localparam logic [FIELD_W-1:0] HALF_Q = FIELD_W'(1) << (FRAC_BITS - 1);

    // hue angles in 1/16 degree
    localparam logic [FIELD_W-1:0] HUE_60   = 13'd960;
    localparam logic [FIELD_W-1:0] HUE_120  = 13'd1920;
    localparam logic [FIELD_W-1:0] HUE_180  = 13'd2880;
    localparam logic [FIELD_W-1:0] HUE_240  = 13'd3840;
    localparam logic [FIELD_W-1:0] HUE_TURN = 13'd5760;
    localparam logic [FIELD_W-1:0] HUE_240_WRAP = HUE_TURN - HUE_120;

    // m2 product: lightness (13b) times up to 2.0 (14b)
    localparam int OPND_W = FIELD_W + 1;
    localparam int PROD_W = FIELD_W + OPND_W;
    localparam int M2_W   = PROD_W - FRAC_BITS;

    // ramp offset t <= 960
    localparam int T_W = 10;
    localparam logic [T_W-1:0] T_MAX = T_W'(HUE_60);

    // d*t / 960 == ((d*t) >> 6) / 15, the /15 done by reciprocal
    localparam int RAMP_P_W       = FIELD_W + T_W;
    localparam int RAMP_DIV_SHIFT = 6;
    localparam int Y_W            = 16;
    localparam int RECIP_W        = 17;
    localparam logic [RECIP_W-1:0] RECIP_15 = 17'd69906;
    localparam int RECIP_SHIFT    = 20;
    localparam int Q_PROD_W       = Y_W + RECIP_W;

    localparam int NUM_LANES = 3;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef enum logic [1:0] {
        SEG_RAMP_UP,
        SEG_HOLD_HI,
        SEG_RAMP_DOWN,
        SEG_HOLD_LO
    } seg_t;

endpackage

// ===== rtl/core/hls_to_rgb_converter.sv =====
// HLS to RGB converter, four register stages, one word in and one word out per cycle while
// the output is not stalled. An accepted word moves through the stage 0 to 3 registers and
// out_valid is the stage 3 valid bit; a stall at the output backs up stage by stage,
// and bubbles inside the pipe are squeezed out before in_ready drops.
// Reset (rst_n, asynchronous, active low) clears every stage valid bit; data regs keep no reset.
`include "hls_to_rgb_converter_defines.svh"

module hls_to_rgb_converter
    import hrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] hue_sixteenths,
    input  logic [FIELD_W-1:0] lightness,
    input  logic [FIELD_W-1:0] saturation,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] red,
    output logic [FIELD_W-1:0] green,
    output logic [FIELD_W-1:0] blue
);

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor
    // loads in the same cycle. Valid bits move with the data.
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic adv0, adv1, adv2, adv3;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= in_valid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: saturate L and S to 1.0, fold hue into one turn, and form
    // the single product that m2 needs: L*(1+S) for L <= 1/2, else L*S.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] h_next, l_next, s_next;
    logic               low_next;
    logic [OPND_W-1:0]  opnd;
    logic [PROD_W-1:0]  prod_next;

    logic [FIELD_W-1:0] h_a_reg, l_a_reg, s_a_reg;
    logic               low_a_reg;
    logic [PROD_W-1:0]  prod_a_reg;

    always_comb
    begin
        h_next    = (hue_sixteenths >= HUE_TURN) ? hue_sixteenths - HUE_TURN : hue_sixteenths;
        l_next    = (lightness > ONE_Q) ? ONE_Q : lightness;
        s_next    = (saturation > ONE_Q) ? ONE_Q : saturation;
        low_next  = (l_next <= HALF_Q);
        opnd      = low_next ? (OPND_W'(s_next) + OPND_W'(ONE_Q)) : OPND_W'(s_next);
        prod_next = PROD_W'(l_next) * PROD_W'(opnd);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && adv0)
        begin
            h_a_reg    <= h_next;
            l_a_reg    <= l_next;
            s_a_reg    <= s_next;
            low_a_reg  <= low_next;
            prod_a_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: m2, m1 and, per channel, the hue segment and ramp offset.
    // Red sits at hue+120 deg, green at hue, blue at hue-120 deg.
    // ------------------------------------------------------------------
    logic [M2_W-1:0]    prod_sh;
    logic [M2_W-1:0]    m2_raw;
    logic [FIELD_W:0]   twice_l;
    logic [FIELD_W:0]   m1_diff;
    logic [FIELD_W-1:0] m2_next, m1_next;
    logic [FIELD_W-1:0] ang [NUM_LANES];
    seg_t               seg_next [NUM_LANES];
    logic [T_W-1:0]     t_next [NUM_LANES];

    logic [FIELD_W-1:0] m1_b_reg, m2_b_reg;
    seg_t               seg_b_reg [NUM_LANES];
    logic [T_W-1:0]     t_b_reg [NUM_LANES];

    always_comb
    begin
        prod_sh = prod_a_reg[PROD_W-1:FRAC_BITS];
        if (low_a_reg)
        begin
            m2_raw = prod_sh;
        end
        else
        begin
            m2_raw = M2_W'(l_a_reg) + M2_W'(s_a_reg) - prod_sh;
        end
        m2_next = (m2_raw > M2_W'(ONE_Q)) ? ONE_Q : m2_raw[FIELD_W-1:0];

        twice_l = {l_a_reg, 1'b0};
        m1_diff = twice_l - (FIELD_W + 1)'(m2_next);
        if (twice_l <= (FIELD_W + 1)'(m2_next))
        begin
            m1_next = '0;
        end
        else if (m1_diff > (FIELD_W + 1)'(ONE_Q))
        begin
            m1_next = ONE_Q;
        end
        else
        begin
            m1_next = m1_diff[FIELD_W-1:0];
        end

        ang[LANE_RED]   = (h_a_reg >= HUE_240_WRAP) ? h_a_reg - HUE_240_WRAP
                                                    : h_a_reg + HUE_120;
        ang[LANE_GREEN] = h_a_reg;
        ang[LANE_BLUE]  = (h_a_reg >= HUE_120) ? h_a_reg - HUE_120
                                               : h_a_reg + HUE_240_WRAP;

        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (ang[k] < HUE_60)
            begin
                seg_next[k] = SEG_RAMP_UP;
                t_next[k]   = ang[k][T_W-1:0];
            end
            else if (ang[k] < HUE_180)
            begin
                seg_next[k] = SEG_HOLD_HI;
                t_next[k]   = '0;
            end
            else if (ang[k] < HUE_240)
            begin
                seg_next[k] = SEG_RAMP_DOWN;
                t_next[k]   = T_W'(HUE_240 - ang[k]);
            end
            else
            begin
                seg_next[k] = SEG_HOLD_LO;
                t_next[k]   = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v0_reg && adv1)
        begin
            m1_b_reg  <= m1_next;
            m2_b_reg  <= m2_next;
            seg_b_reg <= seg_next;
            t_b_reg   <= t_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: (m2-m1)*t per channel, pre-divided by 64. m2 >= m1 always,
    // so the ramp height is unsigned.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0]  d_span;
    logic [RAMP_P_W-1:0] ramp_p [NUM_LANES];
    logic [Y_W-1:0]      y_next [NUM_LANES];

    logic [FIELD_W-1:0]  m1_c_reg, m2_c_reg;
    seg_t                seg_c_reg [NUM_LANES];
    logic [Y_W-1:0]      y_c_reg [NUM_LANES];

    always_comb
    begin
        d_span = m2_b_reg - m1_b_reg;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            ramp_p[k] = RAMP_P_W'(d_span) * RAMP_P_W'(t_b_reg[k]);
            y_next[k] = ramp_p[k][RAMP_DIV_SHIFT +: Y_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && adv2)
        begin
            m1_c_reg  <= m1_b_reg;
            m2_c_reg  <= m2_b_reg;
            seg_c_reg <= seg_b_reg;
            y_c_reg   <= y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 15 through the reciprocal (exact over the whole
    // y range), pick the segment value, clamp to 1.0, register outputs.
    // ------------------------------------------------------------------
    logic [Q_PROD_W-1:0] q_prod [NUM_LANES];
    logic [FIELD_W-1:0]  q_val [NUM_LANES];
    logic [FIELD_W:0]    v_sum [NUM_LANES];
    logic [FIELD_W-1:0]  chan_next [NUM_LANES];

    logic [FIELD_W-1:0]  red_reg, green_reg, blue_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            q_prod[k] = Q_PROD_W'(y_c_reg[k]) * Q_PROD_W'(RECIP_15);
            q_val[k]  = q_prod[k][RECIP_SHIFT +: FIELD_W];
            v_sum[k]  = (FIELD_W + 1)'(m1_c_reg) + (FIELD_W + 1)'(q_val[k]);
            case (seg_c_reg[k])
                SEG_RAMP_UP, SEG_RAMP_DOWN:
                begin
                    chan_next[k] = (v_sum[k] > (FIELD_W + 1)'(ONE_Q))
                                 ? ONE_Q : v_sum[k][FIELD_W-1:0];
                end
                SEG_HOLD_HI:
                begin
                    chan_next[k] = m2_c_reg;
                end
                default:
                begin
                    chan_next[k] = m1_c_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && adv3)
        begin
            red_reg   <= chan_next[LANE_RED];
            green_reg <= chan_next[LANE_GREEN];
            blue_reg  <= chan_next[LANE_BLUE];
        end
    end

    assign out_valid = v3_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `HRC_ASSERT_NEXT(a_accept_fills_s0, in_valid && in_ready, v0_reg, "accepted word not in stage 0")
    `HRC_ASSERT_SAME(a_m1_le_m2, v1_reg, m1_b_reg <= m2_b_reg, "m1 above m2")
    `HRC_ASSERT_SAME(a_ramp_span, v1_reg, (t_b_reg[LANE_RED] <= T_MAX) && (t_b_reg[LANE_GREEN] <= T_MAX) && (t_b_reg[LANE_BLUE] <= T_MAX), "ramp offset past 60 deg")
    `HRC_ASSERT_SAME(a_out_range, out_valid, (red <= ONE_Q) && (green <= ONE_Q) && (blue <= ONE_Q), "channel above 1.0")

endmodule

// ===== tb/hls_to_rgb_converter_tb.sv =====
localparam int     WORD_W    = hrc_pkg::FIELD_W;
localparam int     Q_BITS    = hrc_pkg::FRAC_BITS;
localparam longint UNIT_Q    = longint'(hrc_pkg::ONE_Q);
localparam longint HALF_UNIT = longint'(hrc_pkg::HALF_Q);
localparam longint DEG_60    = longint'(hrc_pkg::HUE_60);
localparam longint DEG_120   = longint'(hrc_pkg::HUE_120);
localparam longint DEG_180   = longint'(hrc_pkg::HUE_180);
localparam longint DEG_240   = longint'(hrc_pkg::HUE_240);
localparam longint FULL_TURN = longint'(hrc_pkg::HUE_TURN);

typedef struct packed {
    logic [WORD_W-1:0] hue;
    logic [WORD_W-1:0] light;
    logic [WORD_W-1:0] sat;
    logic [WORD_W-1:0] red;
    logic [WORD_W-1:0] green;
    logic [WORD_W-1:0] blue;
} color_word_t;

class rgb_scoreboard;
    color_word_t pending_rgb[$];
    int          mismatches;
    int          checked;

    function longint clamp_unit(longint v);
        if (v < 0)
            return 0;
        if (v > UNIT_Q)
            return UNIT_Q;
        return v;
    endfunction

    // one channel: ramp up, hold m2, ramp down, hold m1 over a wrapped angle
    function logic [WORD_W-1:0] ramp_level(longint lo, longint hi, longint ang);
        longint v;
        while (ang >= FULL_TURN)
            ang -= FULL_TURN;
        while (ang < 0)
            ang += FULL_TURN;
        if (ang < DEG_60)
            v = lo + ((hi - lo) * ang) / DEG_60;
        else if (ang < DEG_180)
            v = hi;
        else if (ang < DEG_240)
            v = lo + ((hi - lo) * (DEG_240 - ang)) / DEG_60;
        else
            v = lo;
        return WORD_W'(clamp_unit(v));
    endfunction

    function color_word_t hls_to_rgb(logic [WORD_W-1:0] hue, logic [WORD_W-1:0] light,
                                     logic [WORD_W-1:0] sat);
        color_word_t c;
        longint      h;
        longint      l;
        longint      s;
        longint      m1;
        longint      m2;
        h = hue;
        if (h >= FULL_TURN)
            h -= FULL_TURN;
        l = clamp_unit(light);
        s = clamp_unit(sat);
        if (l <= HALF_UNIT)
            m2 = (l * (s + UNIT_Q)) >>> Q_BITS;
        else
            m2 = l + s - ((l * s) >>> Q_BITS);
        m2 = clamp_unit(m2);
        m1 = clamp_unit(2 * l - m2);
        c.hue   = hue;
        c.light = light;
        c.sat   = sat;
        c.red   = ramp_level(m1, m2, h + DEG_120);
        c.green = ramp_level(m1, m2, h);
        c.blue  = ramp_level(m1, m2, h - DEG_120);
        return c;
    endfunction

    function void note_color(logic [WORD_W-1:0] hue, logic [WORD_W-1:0] light,
                             logic [WORD_W-1:0] sat);
        pending_rgb.push_back(hls_to_rgb(hue, light, sat));
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task check_rgb(logic [WORD_W-1:0] r, logic [WORD_W-1:0] g, logic [WORD_W-1:0] b);
        color_word_t want;
        string       tag;
        if (pending_rgb.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d", r, g, b));
            return;
        end
        want = pending_rgb.pop_front();
        checked++;
        tag  = $sformatf("h=%0d l=%0d s=%0d", want.hue, want.light, want.sat);
        if (r !== want.red)
            report_mismatch($sformatf("%s red got %0d want %0d", tag, r, want.red));
        if (g !== want.green)
            report_mismatch($sformatf("%s green got %0d want %0d", tag, g, want.green));
        if (b !== want.blue)
            report_mismatch($sformatf("%s blue got %0d want %0d", tag, b, want.blue));
    endtask
endclass

module hls_to_rgb_converter_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 200000;  // watchdog bound, far above any real run
    localparam int HOLD_CYCLES  = 80;      // long output hold-off, well past pipe depth
    localparam int DRAIN_CYCLES = 20;      // pipe is four stages deep
    localparam int MAX_GAP      = 12;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [WORD_W-1:0] hue_sixteenths;
    logic [WORD_W-1:0] lightness;
    logic [WORD_W-1:0] saturation;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [WORD_W-1:0] red;
    logic [WORD_W-1:0] green;
    logic [WORD_W-1:0] blue;

    rgb_scoreboard sb;

    int sender_idle_pct = 0;  // chance per cycle that the sender sits idle
    int recv_stall_pct  = 0;  // chance per cycle that the receiver drops ready
    bit hold_off        = 1'b0;
    int cycle_count     = 0;
    int colors_sent     = 0;
    int colors_odd      = 0;  // words with a field beyond its nominal range

    hls_to_rgb_converter uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hue_sixteenths (hue_sixteenths),
        .lightness      (lightness),
        .saturation     (saturation),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog: a hung handshake or a lost word ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, sb.pending_rgb.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: ready is redrawn at every falling edge; hold_off overrides it.
    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);

    // Output monitor, sampled at the rising edge before the block updates.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_rgb(red, green, blue);

    // Hold the output off for a fixed stretch, counted in its own process on the
    // rising edge so the receiver (falling edge) never races it.
    task hold_output();
        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
    endtask

    // Entered and left just after a falling edge. Valid stays high after the
    // handshake; a gap in the next call or the caller takes it down at that edge.
    task send_word(logic [WORD_W-1:0] h, logic [WORD_W-1:0] l, logic [WORD_W-1:0] s);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        hue_sixteenths <= h;
        lightness      <= l;
        saturation     <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_color(h, l, s);
        colors_sent++;
        if (h >= hrc_pkg::HUE_TURN || l > hrc_pkg::ONE_Q || s > hrc_pkg::ONE_Q)
            colors_odd++;
        @(negedge clk);
    endtask

    // Mix: mostly nominal colors, some hues sitting on segment edges,
    // some lightness around one half, and a share of raw 13-bit noise.
    task pick_color(output logic [WORD_W-1:0] h, output logic [WORD_W-1:0] l,
                    output logic [WORD_W-1:0] s);
        int kind;
        int edge_hue;
        kind = $urandom_range(0, 99);
        h    = WORD_W'($urandom_range(0, FULL_TURN - 1));
        l    = WORD_W'($urandom_range(0, UNIT_Q));
        s    = WORD_W'($urandom_range(0, UNIT_Q));
        if (kind < 12)
        begin
            h = WORD_W'($urandom);
            l = WORD_W'($urandom);
            s = WORD_W'($urandom);
        end
        else if (kind < 30)
        begin
            edge_hue = int'(longint'($urandom_range(0, 6)) * DEG_60
                            + longint'($urandom_range(0, 4)) - 2);
            if (edge_hue < 0)
                edge_hue += FULL_TURN;
            h = WORD_W'(edge_hue);
        end
        else if (kind < 40)
        begin
            l = WORD_W'(HALF_UNIT + $urandom_range(0, 4) - 2);
            if ($urandom_range(0, 1) == 1)
                s = $urandom_range(0, 1) == 1 ? WORD_W'(UNIT_Q) : '0;
        end
    endtask

    task send_random(int count);
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] l;
        logic [WORD_W-1:0] s;
        repeat (count)
        begin
            pick_color(h, l, s);
            send_word(h, l, s);
        end
    endtask

    // Drop the input valid and switch the idling mix at a rising edge.
    task set_idling(int sender_pct, int recv_pct);
        in_valid <= 1'b0;
        @(posedge clk);
        sender_idle_pct = sender_pct;
        recv_stall_pct  = recv_pct;
        @(negedge clk);
    endtask

    initial
    begin
        sb             = new;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        hue_sixteenths = '0;
        lightness      = '0;
        saturation     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every segment edge of the hue ramp, the wrap past one turn,
        // lightness on both sides of one half, and saturated over-range operands.
        send_word(13'd0,    13'd2048, 13'd4096);
        send_word(13'd959,  13'd2048, 13'd4096);
        send_word(13'd960,  13'd2048, 13'd4096);
        send_word(13'd1919, 13'd1000, 13'd3000);
        send_word(13'd1920, 13'd1000, 13'd3000);
        send_word(13'd2879, 13'd3000, 13'd2000);
        send_word(13'd2880, 13'd3000, 13'd2000);
        send_word(13'd3839, 13'd2049, 13'd4095);
        send_word(13'd3840, 13'd2049, 13'd4095);
        send_word(13'd4799, 13'd2047, 13'd1);
        send_word(13'd4800, 13'd2047, 13'd1);
        send_word(13'd5759, 13'd1234, 13'd4096);
        send_word(13'd5760, 13'd1234, 13'd4096);   // wraps to zero
        send_word(13'd8191, 13'd2500, 13'd3500);   // largest hue, wraps once
        send_word(13'd700,  13'd0,    13'd4096);   // black
        send_word(13'd700,  13'd4096, 13'd4096);   // white
        send_word(13'd700,  13'd4097, 13'd100);    // lightness saturates
        send_word(13'd700,  13'd8191, 13'd8191);
        send_word(13'd3000, 13'd2000, 13'd4097);   // saturation saturates
        send_word(13'd3000, 13'd3000, 13'd8191);
        send_word(13'd4000, 13'd2048, 13'd0);      // grey, no chroma
        send_word(13'd4000, 13'd8191, 13'd0);
        send_word(13'd2000, 13'd0,    13'd0);
        send_word(13'd6000, 13'd1,    13'd1);

        send_random(150);
        set_idling(69, 0);
        send_random(130);
        set_idling(0, 69);
        send_random(130);
        set_idling(15, 15);
        send_random(110);

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the pipe fills and in_ready has to drop.
        set_idling(0, 0);
        hold_output();
        send_random(40);
        in_valid <= 1'b0;

        while (sb.pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d colors (%0d with a field beyond its range), %0d results checked.",
                 colors_sent, colors_odd, sb.checked);
        $display("Flow: free-running, sparse input, stalling output, both, and a long hold-off.");
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
